>>> rtl/assert_macros.svh
// assertion macros shared by the dequantizer rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BDQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define BDQ_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define BDQ_ASSERT(lbl, clk, rstn, prop)
`define BDQ_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> rtl/nvfp4_bdq_pkg.sv
// types, constants and decode functions of the nvfp4 block dequantizer
// no dependencies
`default_nettype none
package nvfp4_bdq_pkg;

  localparam logic [5:0]  LastPos          = 6'd35;
  localparam logic [5:0]  ScaleBytes       = 6'd4;
  localparam logic [31:0] GlobalScaleReset = 32'h3F80_0000;
  localparam logic [31:0] CanonNan         = 32'h7FC0_0000;

  // e2m1 magnitudes as integer significand times 2^-1
  localparam logic [3:0] E2m1Sig [8] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd12};

  typedef struct packed {
    logic       is_scale;
    logic [1:0] slot;
    logic [2:0] lane;
    logic       last;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic       is_scale;
    logic [1:0] slot;
    logic [5:0] index;
    logic       last;
  } tag_t;

  // narrow operand: (-1)^sign * sig * 2^exp
  typedef struct packed {
    logic              sign;
    logic              nan;
    logic [3:0]        sig;
    logic signed [4:0] exp;
  } small_op_t;

  typedef struct packed {
    logic [31:0] a;
    small_op_t   b;
    tag_t        tag;
  } mul_op_t;

  typedef enum logic {
    IssLo,
    IssHi
  } issue_state_e;

  function automatic small_op_t e4m3_decode(input logic [7:0] v);
    small_op_t  r;
    logic [3:0] e;
    logic [2:0] m;
    e      = v[6:3];
    m      = v[2:0];
    r.sign = v[7];
    r.nan  = (e == 4'hF) && (m == 3'h7);
    if (e == 4'd0) begin
      r.sig = {1'b0, m};
      r.exp = -5'sd9;
    end else begin
      r.sig = {1'b1, m};
      r.exp = $signed({1'b0, e}) - 5'sd10;
    end
    return r;
  endfunction

  function automatic small_op_t e2m1_decode(input logic [3:0] nib);
    small_op_t r;
    r.sign = nib[3];
    r.nan  = 1'b0;
    r.sig  = E2m1Sig[nib[2:0]];
    r.exp  = -5'sd1;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/nvfp4_bdq_if.sv
// valid/ready channel interfaces for the byte input and the result output
// no dependencies
`default_nettype none
interface nvfp4_bdq_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface nvfp4_bdq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;
  logic [5:0]  element_index;
  logic        block_done;
  modport source (output valid, output value_bits, output element_index, output block_done,
                  input ready);
  modport sink (input valid, input value_bits, input element_index, input block_done,
                output ready);
endinterface
`default_nettype wire

>>> rtl/nvfp4_bdq_queue.sv
// small command fifo between front and back
// depends on nvfp4_bdq_pkg
`default_nettype none
module nvfp4_bdq_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  nvfp4_bdq_pkg::cmd_t  push_data_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output nvfp4_bdq_pkg::cmd_t  pop_data_o,
  output logic                 valid_o
);
  import nvfp4_bdq_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/nvfp4_bdq_front.sv
// front: takes stream bytes, tracks the block position, classifies each byte
// depends on nvfp4_bdq_pkg and nvfp4_bdq_if
`default_nettype none
module nvfp4_bdq_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  nvfp4_bdq_in_if.sink        in_i,
  input  wire                 full_i,
  output logic                push_o,
  output nvfp4_bdq_pkg::cmd_t cmd_o
);
  import nvfp4_bdq_pkg::*;

  logic [5:0] pos_q, pos_d;
  logic [5:0] nib_pos;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign nib_pos    = pos_q - ScaleBytes;

  always_comb begin
    cmd_o.is_scale = (pos_q < ScaleBytes);
    cmd_o.slot     = cmd_o.is_scale ? pos_q[1:0] : nib_pos[4:3];
    cmd_o.lane     = nib_pos[2:0];
    cmd_o.last     = (pos_q == LastPos);
    cmd_o.data     = in_i.data_byte;
  end

  always_comb begin
    pos_d = pos_q;
    if (push_o) begin
      pos_d = (pos_q >= LastPos) ? '0 : pos_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/nvfp4_bdq_fmul.sv
// binary32 by narrow-operand multiplier, round to nearest even, two register stages
// depends on nvfp4_bdq_pkg
`default_nettype none
module nvfp4_bdq_fmul (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    en_i,
  input  wire                    valid_i,
  input  nvfp4_bdq_pkg::mul_op_t op_i,
  output logic                   valid_o,
  output nvfp4_bdq_pkg::tag_t    tag_o,
  output logic [31:0]            result_o
);
  import nvfp4_bdq_pkg::*;

  // stage 1: significand product and exponent of its lsb
  logic [7:0]        a_exp, exp_eff;
  logic [22:0]       a_frac;
  logic [23:0]       sig_a;
  logic              a_nan, a_inf, b_zero;
  logic              s1_valid_q;
  logic [27:0]       s1_prod_q, s1_prod_d;
  logic signed [9:0] s1_exp_q, s1_exp_d;
  logic              s1_sign_q, s1_nan_q, s1_inf_q;
  logic              s1_nan_d, s1_inf_d;
  tag_t              s1_tag_q;

  assign a_exp   = op_i.a[30:23];
  assign a_frac  = op_i.a[22:0];
  assign sig_a   = {(a_exp != 8'd0), a_frac};
  assign exp_eff = (a_exp == 8'd0) ? 8'd1 : a_exp;
  assign a_nan   = (a_exp == 8'hFF) && (a_frac != '0);
  assign a_inf   = (a_exp == 8'hFF) && (a_frac == '0);
  assign b_zero  = (op_i.b.sig == 4'd0);

  assign s1_nan_d  = a_nan || op_i.b.nan || (a_inf && b_zero);
  assign s1_inf_d  = a_inf && !op_i.b.nan && !b_zero;
  assign s1_prod_d = {4'd0, sig_a} * {24'd0, op_i.b.sig};
  assign s1_exp_d  = $signed({2'b00, exp_eff}) - 10'sd150
                   + $signed({{5{op_i.b.exp[4]}}, op_i.b.exp});

  // stage 2: leading one, lsb exponent of the result and alignment shift
  logic [4:0]        lead;
  logic signed [9:0] l_raw, l_sel, sh_full, base_full;
  logic              s2_valid_q;
  logic [27:0]       s2_prod_q;
  logic signed [5:0] s2_sh_q;
  logic [8:0]        s2_base_q;
  logic              s2_sign_q, s2_nan_q, s2_inf_q, s2_zero_q;
  tag_t              s2_tag_q;

  always_comb begin
    lead = '0;
    for (int i = 0; i < 28; i++) begin
      if (s1_prod_q[i]) begin
        lead = 5'(i);
      end
    end
    l_raw     = $signed({5'd0, lead}) + s1_exp_q - 10'sd23;
    l_sel     = (l_raw < -10'sd149) ? -10'sd149 : l_raw;
    sh_full   = l_sel - s1_exp_q;
    base_full = l_sel + 10'sd149;
  end

  // stage 3: shift, round, pack
  logic signed [5:0] neg_sh;
  logic [27:0]       lshift;
  logic [36:0]       rshift;
  logic [23:0]       mant;
  logic              rbit, sticky, rnd;
  logic [32:0]       sum;

  always_comb begin
    neg_sh = -s2_sh_q;
    lshift = s2_prod_q << neg_sh[4:0];
    rshift = {s2_prod_q, 9'd0} >> s2_sh_q[3:0];
    if (s2_sh_q[5]) begin
      mant   = lshift[23:0];
      rbit   = 1'b0;
      sticky = 1'b0;
    end else begin
      mant   = rshift[32:9];
      rbit   = rshift[8];
      sticky = |rshift[7:0];
    end
    rnd = rbit && (sticky || mant[0]);
    sum = {1'b0, s2_base_q, 23'd0} + {9'd0, mant} + {32'd0, rnd};
    if (s2_nan_q) begin
      result_o = CanonNan;
    end else if (s2_inf_q || (sum >= 33'h0_7F80_0000)) begin
      result_o = {s2_sign_q, 8'hFF, 23'd0};
    end else if (s2_zero_q) begin
      result_o = {s2_sign_q, 31'd0};
    end else begin
      result_o = {s2_sign_q, sum[30:0]};
    end
  end

  assign valid_o = s2_valid_q;
  assign tag_o   = s2_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_prod_q <= s1_prod_d;
      s1_exp_q  <= s1_exp_d;
      s1_sign_q <= op_i.a[31] ^ op_i.b.sign;
      s1_nan_q  <= s1_nan_d;
      s1_inf_q  <= s1_inf_d;
      s1_tag_q  <= op_i.tag;
      s2_prod_q <= s1_prod_q;
      s2_sh_q   <= sh_full[5:0];
      s2_base_q <= base_full[8:0];
      s2_sign_q <= s1_sign_q;
      s2_nan_q  <= s1_nan_q;
      s2_inf_q  <= s1_inf_q;
      s2_zero_q <= (s1_prod_q == '0);
      s2_tag_q  <= s1_tag_q;
    end
  end

endmodule
`default_nettype wire

>>> rtl/nvfp4_bdq_back.sv
// back: issues scale and nibble products, keeps group scales, drives the result register
// depends on nvfp4_bdq_pkg, nvfp4_bdq_if, nvfp4_bdq_fmul and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"
module nvfp4_bdq_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cmd_valid_i,
  input  nvfp4_bdq_pkg::cmd_t cmd_i,
  output logic                cmd_pop_o,
  input  wire [31:0]          tensor_scale_i,
  nvfp4_bdq_out_if.source     out_o
);
  import nvfp4_bdq_pkg::*;

  issue_state_e state_q, state_d;
  logic         adv, issue, hi_sel;
  mul_op_t      op;
  logic         mul_valid;
  tag_t         mul_tag;
  logic [31:0]  mul_result;
  logic [31:0]  grp_scale_q [4];
  logic         out_valid_q, out_valid_d, out_load;
  logic [31:0]  out_value_q;
  logic [5:0]   out_index_q;
  logic         out_done_q;

  assign adv   = !out_valid_q || out_o.ready;
  assign issue = cmd_valid_i && adv;

  always_comb begin
    state_d = state_q;
    case (state_q)
      IssLo: begin
        if (issue && !cmd_i.is_scale) begin
          state_d = IssHi;
        end
      end
      IssHi: begin
        if (issue) begin
          state_d = IssLo;
        end
      end
      default: begin
        state_d = IssLo;
      end
    endcase
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    hi_sel    = 1'b0;
    case (state_q)
      IssLo: begin
        cmd_pop_o = issue && cmd_i.is_scale;
      end
      IssHi: begin
        cmd_pop_o = issue;
        hi_sel    = 1'b1;
      end
      default: begin
        cmd_pop_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    op.tag.is_scale = cmd_i.is_scale;
    op.tag.slot     = cmd_i.slot;
    op.tag.index    = {cmd_i.slot, hi_sel, cmd_i.lane};
    op.tag.last     = cmd_i.last && hi_sel;
    if (cmd_i.is_scale) begin
      op.a = tensor_scale_i;
      op.b = e4m3_decode(cmd_i.data);
    end else begin
      op.a = grp_scale_q[cmd_i.slot];
      op.b = e2m1_decode(hi_sel ? cmd_i.data[7:4] : cmd_i.data[3:0]);
    end
  end

  nvfp4_bdq_fmul u_fmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (issue),
    .op_i     (op),
    .valid_o  (mul_valid),
    .tag_o    (mul_tag),
    .result_o (mul_result)
  );

  assign out_load    = adv && mul_valid && !mul_tag.is_scale;
  assign out_valid_d = adv ? (mul_valid && !mul_tag.is_scale) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IssLo;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && mul_valid && mul_tag.is_scale) begin
      grp_scale_q[mul_tag.slot] <= mul_result;
    end
    if (out_load) begin
      out_value_q <= mul_result;
      out_index_q <= mul_tag.index;
      out_done_q  <= mul_tag.last;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.value_bits    = out_value_q;
  assign out_o.element_index = out_index_q;
  assign out_o.block_done    = out_done_q;

  `BDQ_ASSERT(a_hi_holds_nibble, clk_i, rst_ni, (state_q == IssHi) |-> (cmd_valid_i && !cmd_i.is_scale))
  `BDQ_ASSERT_NEVER(a_done_on_last, clk_i, rst_ni, out_valid_q && out_done_q && (out_index_q != 6'd63))
  `BDQ_ASSERT(a_hi_follows_lo, clk_i, rst_ni, (out_valid_q && out_o.ready && !out_index_q[3]) |=> (out_valid_q && out_index_q[3] && (out_index_q[2:0] == $past(out_index_q[2:0])) && (out_index_q[5:4] == $past(out_index_q[5:4]))))

endmodule
`default_nettype wire

>>> rtl/nvfp4_block_dequantizer.sv
// nvfp4 block dequantizer: a low-nibble result passes the command queue, the multiplier
// register stages and the result register; the high-nibble result of the same byte follows it
// both results of a nibble byte are issued through the single multiplier issue slot,
// one after the other, while a scale byte needs a single issue
// reset: block position and pipeline cleared, global scale back to 1.0,
// group scales undefined until their scale bytes arrive
`default_nettype none
module nvfp4_block_dequantizer #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  nvfp4_bdq_in_if.sink     in_i,
  nvfp4_bdq_out_if.source  out_o,
  input  wire              cfg_we_i,
  input  wire [31:0]       cfg_wdata_i
);
  import nvfp4_bdq_pkg::*;

  logic [31:0] tensor_scale_q;
  logic        push, full, cmd_valid, cmd_pop;
  cmd_t        push_cmd, head_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tensor_scale_q <= GlobalScaleReset;
    end else if (cfg_we_i) begin
      tensor_scale_q <= cfg_wdata_i;
    end
  end

  nvfp4_bdq_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  nvfp4_bdq_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (cmd_pop),
    .pop_data_o  (head_cmd),
    .valid_o     (cmd_valid)
  );

  nvfp4_bdq_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (head_cmd),
    .cmd_pop_o      (cmd_pop),
    .tensor_scale_i (tensor_scale_q),
    .out_o          (out_o)
  );

endmodule
`default_nettype wire
